### hw/rtl/fhf_pkg.sv
`default_nettype none
package fhf_pkg;

   localparam int ROWS        = 32;
   localparam int COLS        = 32;
   localparam int MAX_FLARES  = 32;
   localparam int HEAT_LEVELS = 12;
   localparam int FLARE_ROWS  = 2;
   localparam int GLOW_SCALE  = 10;
   localparam int GLOW_ROUND  = 5;
   localparam int RST_CHANCE  = 50;
   localparam int RST_DECAY   = 14;

   // fixed port field widths
   localparam int FUNC_W  = 2;
   localparam int POS_W   = 5;
   localparam int HW      = 4;
   localparam int ROLL_W  = 7;
   localparam int CSR_W   = 7;
   localparam int COUNT_W = 6;

   localparam int HEAT_MAX = HEAT_LEVELS - 1;
   localparam int DEPTH    = ROWS * COLS;
   localparam int AW       = $clog2(DEPTH);
   localparam int XW       = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int YW       = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int FAW      = (MAX_FLARES > 1) ? $clog2(MAX_FLARES) : 1;
   localparam int FCW      = $clog2(MAX_FLARES + 1);
   localparam int CNTW     = $clog2(((ROWS > COLS) ? ROWS : COLS) + 1);
   localparam int SW       = 2 * CNTW + 1;
   localparam int SQ_ITERS = (SW + 1) / 2;
   localparam int RTW      = SQ_ITERS;
   localparam int DIVW     = $clog2(HEAT_MAX * GLOW_SCALE + 1);
   localparam int BW       = $clog2(HEAT_MAX * GLOW_SCALE + 2);
   localparam int CMPW     = ((DIVW > CSR_W) ? DIVW : CSR_W) + 1;
   localparam int WBW      = ((CNTW > BW) ? CNTW : BW) + 1;
   localparam int MW       = CSR_W + RTW;
   localparam int PW       = MW + 17;
   localparam int DW       = MW - 2;
   localparam int DIV10_MUL = 32'hCCCD;   // x/10 == (x*0xCCCD)>>19 for x < 2^16
   localparam int YMAX     = (FLARE_ROWS - 1 > ROWS - 1) ? ROWS - 1 : FLARE_ROWS - 1;

   localparam logic [FUNC_W-1:0] FUNC_SHIFT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REHEAT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLARE  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

   localparam logic CSR_CHANCE = 1'b0;
   localparam logic CSR_DECAY  = 1'b1;

   typedef struct packed {
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      logic [HW-1:0] z;
   } flare_type;

   localparam int FLW = $bits(flare_type);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_SHF_RD, ST_SHF_WR, ST_HT_RD, ST_HT_WR, ST_RD_RD, ST_RD_CAP,
      ST_FL_NEXT, ST_FL_LOAD, ST_NEW_CHK, ST_NEW, ST_DIV, ST_WIN, ST_PX_SET, ST_PX_SQ,
      ST_PX_MUL, ST_PX_DIV, ST_PX_CMP, ST_FL_DEC, ST_MV_RD, ST_MV_WR, ST_MV_END, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_CLR, CMD_START, CMD_SHF_RD, CMD_SHF_WR, CMD_HT_RD, CMD_HT_WR,
      CMD_RD_RD, CMD_RD_CAP, CMD_FL_RD, CMD_FL_LOAD, CMD_NEW, CMD_DIV, CMD_WIN,
      CMD_PX_SET, CMD_PX_MUL, CMD_PX_DIV, CMD_PX_CMP, CMD_FL_DEC, CMD_MV_RD,
      CMD_MV_WR, CMD_MV_END
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic shf_last;
      logic k_lt;
      logic div_done;
      logic sq_done;
      logic px_last;
      logic z_gt1;
      logic is_new;
      logic m_lt;
      logic new_ok;
   } status_type;

   function automatic logic [AW-1:0] heat_addr(input int r, input int c);
      return AW'(r * COLS + c);
   endfunction

endpackage
`default_nettype wire

### hw/rtl/fhf_ram.sv
`default_nettype none
module fhf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

### hw/rtl/fhf_isqrt.sv
`default_nettype none
module fhf_isqrt (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [fhf_pkg::SW-1:0]   value,
   output logic                          done,
   output logic      [fhf_pkg::RTW-1:0]  root
);

   localparam int QW = 2 * fhf_pkg::SQ_ITERS;
   localparam int IW = $clog2(fhf_pkg::SQ_ITERS + 1);

   logic [QW-1:0] v_ff, v_in, root_ff, root_in, bit_ff, bit_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [QW-1:0] trial;

   // one result digit per cycle
   always_comb begin
      v_in    = v_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      trial   = root_ff + bit_ff;
      if (start) begin
         v_in    = QW'(value);
         root_in = '0;
         bit_in  = QW'(1) << (QW - 2);
         cnt_in  = IW'(fhf_pkg::SQ_ITERS);
      end else if (cnt_ff != '0) begin
         if (v_ff >= trial) begin
            v_in    = v_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      v_ff    <= v_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign done = (cnt_ff == '0);
   assign root = root_ff[fhf_pkg::RTW-1:0];

endmodule
`default_nettype wire

### hw/rtl/fhf_datapath.sv
`default_nettype none
module fhf_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fhf_pkg::cmd_type              cmd,
   output fhf_pkg::status_type                status,
   input  wire logic [fhf_pkg::POS_W-1:0]     req_pixel_column,
   input  wire logic [fhf_pkg::POS_W-1:0]     req_pixel_row,
   input  wire logic [fhf_pkg::HW-1:0]        req_heat_value,
   input  wire logic [fhf_pkg::ROLL_W-1:0]    req_chance_roll,
   input  wire logic [fhf_pkg::POS_W-1:0]     req_flare_x,
   input  wire logic [fhf_pkg::POS_W-1:0]     req_flare_y,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [fhf_pkg::CSR_W-1:0]     csr_wdata,
   output logic      [fhf_pkg::HW-1:0]        heat_out,
   output logic      [fhf_pkg::COUNT_W-1:0]   flare_count
);

   localparam int AW   = fhf_pkg::AW;
   localparam int CNTW = fhf_pkg::CNTW;
   localparam int HW   = fhf_pkg::HW;
   localparam int FCW  = fhf_pkg::FCW;
   localparam int FAW  = fhf_pkg::FAW;
   localparam int SW   = fhf_pkg::SW;
   localparam int WBW  = fhf_pkg::WBW;
   localparam int MW   = fhf_pkg::MW;
   localparam int PW   = fhf_pkg::PW;
   localparam int DW   = fhf_pkg::DW;
   localparam int XW   = fhf_pkg::XW;
   localparam int YW   = fhf_pkg::YW;

   logic [AW-1:0]                  clr_addr_ff, clr_addr_in;
   logic [fhf_pkg::POS_W-1:0]      col_ff, col_in, row_ff, row_in, fx_ff, fx_in, fy_ff, fy_in;
   logic [HW-1:0]                  heat_ff, heat_in, result_ff, result_in;
   logic [fhf_pkg::ROLL_W-1:0]     roll_ff, roll_in;
   logic [fhf_pkg::CSR_W-1:0]      chance_ff, chance_in, decay_ff, decay_in, dec;
   logic [CNTW-1:0]                r_ff, r_in, c_ff, c_in, r1_ff, r1_in, c0_ff, c0_in;
   logic [CNTW-1:0]                c1_ff, c1_in;
   logic [FCW-1:0]                 k_ff, k_in, m_ff, m_in, cnt_ff, cnt_in;
   fhf_pkg::flare_type             cur_ff, cur_in, f_wdata, f_rdata, new_flare;
   logic [fhf_pkg::DIVW-1:0]       rem_ff, rem_in;
   logic [fhf_pkg::BW-1:0]         q_ff, q_in;
   logic [MW-1:0]                  m1_ff, m1_in;
   logic [DW-1:0]                  d_ff, d_in;
   logic                           new_ff, new_in;

   logic                           h_we, f_we;
   logic [AW-1:0]                  h_waddr, h_raddr;
   logic [HW-1:0]                  h_wdata, h_rdata;
   logic [FAW-1:0]                 f_waddr, f_raddr;

   logic                           sq_start, sq_done;
   logic [fhf_pkg::RTW-1:0]        sq_root;
   logic [SW-1:0]                  sq_value, dxe, dye;
   logic [CNTW-1:0]                xx, yy, dx, dy;
   logic [WBW-1:0]                 bb, yb, xb;
   logic [PW-1:0]                  dprod;
   logic [DW-1:0]                  zd;
   logic [HW-1:0]                  nval;
   logic                           rem_ge, in_field;

   fhf_ram #(.WIDTH(HW), .DEPTH(fhf_pkg::DEPTH)) u_heat_ram (
      .clock(clock), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
      .raddr(h_raddr), .rdata(h_rdata)
   );

   fhf_ram #(.WIDTH(fhf_pkg::FLW), .DEPTH(fhf_pkg::MAX_FLARES)) u_flare_ram (
      .clock(clock), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
      .raddr(f_raddr), .rdata(f_rdata)
   );

   fhf_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sq_start), .value(sq_value),
      .done(sq_done), .root(sq_root)
   );

   always_comb begin
      dec    = (decay_ff == '0) ? fhf_pkg::CSR_W'(1) : decay_ff;
      rem_ge = fhf_pkg::CMPW'(rem_ff) >= fhf_pkg::CMPW'(dec);
      bb     = WBW'(q_ff) + WBW'(1);
      yb     = WBW'(cur_ff.y);
      xb     = WBW'(cur_ff.x);
      xx     = CNTW'(cur_ff.x);
      yy     = CNTW'(cur_ff.y);
      dx     = (xx >= c_ff) ? xx - c_ff : c_ff - xx;
      dy     = (yy >= r_ff) ? yy - r_ff : r_ff - yy;
      dxe    = SW'(dx);
      dye    = SW'(dy);
      sq_value = dxe * dxe + dye * dye;
      dprod  = (PW'(m1_ff) + PW'(fhf_pkg::GLOW_ROUND)) * PW'(fhf_pkg::DIV10_MUL);
      zd     = DW'(cur_ff.z);
      nval   = (zd > d_ff) ? HW'(zd - d_ff) : '0;
      in_field = (int'(row_ff) < fhf_pkg::ROWS) && (int'(col_ff) < fhf_pkg::COLS);
      new_flare.x = (int'(fx_ff) > fhf_pkg::COLS - 1) ? XW'(fhf_pkg::COLS - 1) : XW'(fx_ff);
      new_flare.y = (int'(fy_ff) > fhf_pkg::YMAX) ? YW'(fhf_pkg::YMAX) : YW'(fy_ff);
      new_flare.z = HW'(fhf_pkg::HEAT_MAX);
   end

   always_comb begin
      clr_addr_in = clr_addr_ff;
      col_in = col_ff;  row_in = row_ff;  fx_in = fx_ff;  fy_in = fy_ff;
      heat_in = heat_ff;  roll_in = roll_ff;  result_in = result_ff;
      chance_in = chance_ff;  decay_in = decay_ff;
      r_in = r_ff;  c_in = c_ff;  r1_in = r1_ff;  c0_in = c0_ff;  c1_in = c1_ff;
      k_in = k_ff;  m_in = m_ff;  cnt_in = cnt_ff;
      cur_in = cur_ff;  rem_in = rem_ff;  q_in = q_ff;
      m1_in = m1_ff;  d_in = d_ff;  new_in = new_ff;
      h_we = 1'b0;  h_waddr = '0;  h_wdata = '0;  h_raddr = '0;
      f_we = 1'b0;  f_waddr = '0;  f_wdata = '0;  f_raddr = '0;
      sq_start = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            fhf_pkg::CSR_CHANCE: chance_in = csr_wdata;
            fhf_pkg::CSR_DECAY:  decay_in  = csr_wdata;
            default: ;
         endcase
      end

      case (cmd)
         fhf_pkg::CMD_CLR: begin
            h_we        = 1'b1;
            h_waddr     = clr_addr_ff;
            h_wdata     = (int'(clr_addr_ff) < fhf_pkg::COLS) ? HW'(fhf_pkg::HEAT_MAX) : '0;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         fhf_pkg::CMD_START: begin
            col_in    = req_pixel_column;
            row_in    = req_pixel_row;
            heat_in   = req_heat_value;
            roll_in   = req_chance_roll;
            fx_in     = req_flare_x;
            fy_in     = req_flare_y;
            result_in = '0;
            r_in      = CNTW'(fhf_pkg::ROWS - 1);
            c_in      = '0;
            k_in      = '0;
         end
         fhf_pkg::CMD_SHF_RD: begin
            h_raddr = fhf_pkg::heat_addr(int'(r_ff) - 1, int'(c_ff));
         end
         fhf_pkg::CMD_SHF_WR: begin
            h_we    = 1'b1;
            h_waddr = fhf_pkg::heat_addr(int'(r_ff), int'(c_ff));
            h_wdata = (h_rdata != '0) ? h_rdata - HW'(1) : '0;
            if (c_ff == CNTW'(fhf_pkg::COLS - 1)) begin
               c_in = '0;
               r_in = r_ff - CNTW'(1);
            end else begin
               c_in = c_ff + CNTW'(1);
            end
         end
         fhf_pkg::CMD_HT_RD: begin
            h_raddr = fhf_pkg::heat_addr(0, int'(col_ff));
         end
         fhf_pkg::CMD_HT_WR: begin
            // unlit or off-field columns stay as they are
            h_we    = (int'(col_ff) < fhf_pkg::COLS) && (h_rdata != '0);
            h_waddr = fhf_pkg::heat_addr(0, int'(col_ff));
            h_wdata = (int'(heat_ff) > fhf_pkg::HEAT_MAX) ? HW'(fhf_pkg::HEAT_MAX) : heat_ff;
         end
         fhf_pkg::CMD_RD_RD: begin
            h_raddr = fhf_pkg::heat_addr(int'(row_ff), int'(col_ff));
         end
         fhf_pkg::CMD_RD_CAP: begin
            result_in = in_field ? h_rdata : '0;
         end
         fhf_pkg::CMD_FL_RD: begin
            f_raddr = k_ff[FAW-1:0];
         end
         fhf_pkg::CMD_FL_LOAD: begin
            cur_in = f_rdata;
            new_in = 1'b0;
            rem_in = fhf_pkg::DIVW'(int'(f_rdata.z) * fhf_pkg::GLOW_SCALE);
            q_in   = '0;
         end
         fhf_pkg::CMD_NEW: begin
            f_we    = 1'b1;
            f_waddr = cnt_ff[FAW-1:0];
            f_wdata = new_flare;
            cur_in  = new_flare;
            new_in  = 1'b1;
            cnt_in  = cnt_ff + FCW'(1);
            rem_in  = fhf_pkg::DIVW'(fhf_pkg::HEAT_MAX * fhf_pkg::GLOW_SCALE);
            q_in    = '0;
         end
         fhf_pkg::CMD_DIV: begin
            if (rem_ge) begin
               rem_in = rem_ff - fhf_pkg::DIVW'(dec);
               q_in   = q_ff + fhf_pkg::BW'(1);
            end
         end
         fhf_pkg::CMD_WIN: begin
            r_in  = (yb >= bb) ? CNTW'(yb - bb) : '0;
            r1_in = (yb + bb > WBW'(fhf_pkg::ROWS)) ? CNTW'(fhf_pkg::ROWS) : CNTW'(yb + bb);
            c_in  = (xb >= bb) ? CNTW'(xb - bb) : '0;
            c0_in = (xb >= bb) ? CNTW'(xb - bb) : '0;
            c1_in = (xb + bb > WBW'(fhf_pkg::COLS)) ? CNTW'(fhf_pkg::COLS) : CNTW'(xb + bb);
         end
         fhf_pkg::CMD_PX_SET: begin
            sq_start = 1'b1;
         end
         fhf_pkg::CMD_PX_MUL: begin
            m1_in = MW'(dec) * MW'(sq_root);
         end
         fhf_pkg::CMD_PX_DIV: begin
            d_in    = dprod[PW-1:19];
            h_raddr = fhf_pkg::heat_addr(int'(r_ff), int'(c_ff));
         end
         fhf_pkg::CMD_PX_CMP: begin
            h_we    = nval > h_rdata;
            h_waddr = fhf_pkg::heat_addr(int'(r_ff), int'(c_ff));
            h_wdata = nval;
            if (c_ff == c1_ff - CNTW'(1)) begin
               c_in = c0_ff;
               r_in = r_ff + CNTW'(1);
            end else begin
               c_in = c_ff + CNTW'(1);
            end
         end
         fhf_pkg::CMD_FL_DEC: begin
            if (!new_ff) begin
               if (cur_ff.z > HW'(1)) begin
                  f_we    = 1'b1;
                  f_waddr = k_ff[FAW-1:0];
                  f_wdata = '{x: cur_ff.x, y: cur_ff.y, z: cur_ff.z - HW'(1)};
                  k_in    = k_ff + FCW'(1);
               end else begin
                  m_in = k_ff + FCW'(1);
               end
            end
         end
         fhf_pkg::CMD_MV_RD: begin
            f_raddr = m_ff[FAW-1:0];
         end
         fhf_pkg::CMD_MV_WR: begin
            f_we    = 1'b1;
            f_waddr = FAW'(m_ff - FCW'(1));
            f_wdata = f_rdata;
            m_in    = m_ff + FCW'(1);
         end
         fhf_pkg::CMD_MV_END: begin
            cnt_in = cnt_ff - FCW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         cnt_ff      <= '0;
         chance_ff   <= fhf_pkg::CSR_W'(fhf_pkg::RST_CHANCE);
         decay_ff    <= fhf_pkg::CSR_W'(fhf_pkg::RST_DECAY);
      end else begin
         clr_addr_ff <= clr_addr_in;
         cnt_ff      <= cnt_in;
         chance_ff   <= chance_in;
         decay_ff    <= decay_in;
      end
      col_ff <= col_in;  row_ff <= row_in;  fx_ff <= fx_in;  fy_ff <= fy_in;
      heat_ff <= heat_in;  roll_ff <= roll_in;  result_ff <= result_in;
      r_ff <= r_in;  c_ff <= c_in;  r1_ff <= r1_in;  c0_ff <= c0_in;  c1_ff <= c1_in;
      k_ff <= k_in;  m_ff <= m_in;
      cur_ff <= cur_in;  rem_ff <= rem_in;  q_ff <= q_in;
      m1_ff <= m1_in;  d_ff <= d_in;  new_ff <= new_in;
   end

   always_comb begin
      status.clr_last = (clr_addr_ff == AW'(fhf_pkg::DEPTH - 1));
      status.shf_last = (r_ff == CNTW'(1)) && (c_ff == CNTW'(fhf_pkg::COLS - 1));
      status.k_lt     = k_ff < cnt_ff;
      status.div_done = !rem_ge;
      status.sq_done  = sq_done;
      status.px_last  = (r_ff == r1_ff - CNTW'(1)) && (c_ff == c1_ff - CNTW'(1));
      status.z_gt1    = cur_ff.z > HW'(1);
      status.is_new   = new_ff;
      status.m_lt     = m_ff < cnt_ff;
      status.new_ok   = (cnt_ff < FCW'(fhf_pkg::MAX_FLARES)) && (roll_ff <= chance_ff);
   end

   assign heat_out    = result_ff;
   assign flare_count = fhf_pkg::COUNT_W'(cnt_ff);

endmodule
`default_nettype wire

### hw/rtl/fhf_controller.sv
`default_nettype none
module fhf_controller (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [fhf_pkg::FUNC_W-1:0] func,
   input  wire fhf_pkg::status_type        status,
   output fhf_pkg::cmd_type                cmd,
   output logic                            busy,
   output logic                            rsp_valid
);

   fhf_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fhf_pkg::ST_CLEAR:   if (status.clr_last) state_in = fhf_pkg::ST_IDLE;
         fhf_pkg::ST_IDLE: begin
            if (start) begin
               unique case (func)
                  fhf_pkg::FUNC_SHIFT:  state_in = fhf_pkg::ST_SHF_RD;
                  fhf_pkg::FUNC_REHEAT: state_in = fhf_pkg::ST_HT_RD;
                  fhf_pkg::FUNC_FLARE:  state_in = fhf_pkg::ST_FL_NEXT;
                  default:              state_in = fhf_pkg::ST_RD_RD;
               endcase
            end
         end
         fhf_pkg::ST_SHF_RD:  state_in = fhf_pkg::ST_SHF_WR;
         fhf_pkg::ST_SHF_WR:  state_in = status.shf_last ? fhf_pkg::ST_DONE : fhf_pkg::ST_SHF_RD;
         fhf_pkg::ST_HT_RD:   state_in = fhf_pkg::ST_HT_WR;
         fhf_pkg::ST_HT_WR:   state_in = fhf_pkg::ST_DONE;
         fhf_pkg::ST_RD_RD:   state_in = fhf_pkg::ST_RD_CAP;
         fhf_pkg::ST_RD_CAP:  state_in = fhf_pkg::ST_DONE;
         fhf_pkg::ST_FL_NEXT: state_in = status.k_lt ? fhf_pkg::ST_FL_LOAD : fhf_pkg::ST_NEW_CHK;
         fhf_pkg::ST_FL_LOAD: state_in = fhf_pkg::ST_DIV;
         fhf_pkg::ST_NEW_CHK: state_in = status.new_ok ? fhf_pkg::ST_NEW : fhf_pkg::ST_DONE;
         fhf_pkg::ST_NEW:     state_in = fhf_pkg::ST_DIV;
         fhf_pkg::ST_DIV:     if (status.div_done) state_in = fhf_pkg::ST_WIN;
         fhf_pkg::ST_WIN:     state_in = fhf_pkg::ST_PX_SET;
         fhf_pkg::ST_PX_SET:  state_in = fhf_pkg::ST_PX_SQ;
         fhf_pkg::ST_PX_SQ:   if (status.sq_done) state_in = fhf_pkg::ST_PX_MUL;
         fhf_pkg::ST_PX_MUL:  state_in = fhf_pkg::ST_PX_DIV;
         fhf_pkg::ST_PX_DIV:  state_in = fhf_pkg::ST_PX_CMP;
         fhf_pkg::ST_PX_CMP:  state_in = status.px_last ? fhf_pkg::ST_FL_DEC : fhf_pkg::ST_PX_SET;
         fhf_pkg::ST_FL_DEC: begin
            if (status.is_new)     state_in = fhf_pkg::ST_DONE;
            else if (status.z_gt1) state_in = fhf_pkg::ST_FL_NEXT;
            else                   state_in = fhf_pkg::ST_MV_RD;
         end
         fhf_pkg::ST_MV_RD:   state_in = status.m_lt ? fhf_pkg::ST_MV_WR : fhf_pkg::ST_MV_END;
         fhf_pkg::ST_MV_WR:   state_in = fhf_pkg::ST_MV_RD;
         fhf_pkg::ST_MV_END:  state_in = fhf_pkg::ST_FL_NEXT;
         fhf_pkg::ST_DONE:    state_in = fhf_pkg::ST_IDLE;
         default:             state_in = fhf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = fhf_pkg::CMD_NONE;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         fhf_pkg::ST_CLEAR:   cmd = fhf_pkg::CMD_CLR;
         fhf_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) cmd = fhf_pkg::CMD_START;
         end
         fhf_pkg::ST_SHF_RD:  cmd = fhf_pkg::CMD_SHF_RD;
         fhf_pkg::ST_SHF_WR:  cmd = fhf_pkg::CMD_SHF_WR;
         fhf_pkg::ST_HT_RD:   cmd = fhf_pkg::CMD_HT_RD;
         fhf_pkg::ST_HT_WR:   cmd = fhf_pkg::CMD_HT_WR;
         fhf_pkg::ST_RD_RD:   cmd = fhf_pkg::CMD_RD_RD;
         fhf_pkg::ST_RD_CAP:  cmd = fhf_pkg::CMD_RD_CAP;
         fhf_pkg::ST_FL_NEXT: cmd = fhf_pkg::CMD_FL_RD;
         fhf_pkg::ST_FL_LOAD: cmd = fhf_pkg::CMD_FL_LOAD;
         fhf_pkg::ST_NEW:     cmd = fhf_pkg::CMD_NEW;
         fhf_pkg::ST_DIV:     cmd = fhf_pkg::CMD_DIV;
         fhf_pkg::ST_WIN:     cmd = fhf_pkg::CMD_WIN;
         fhf_pkg::ST_PX_SET:  cmd = fhf_pkg::CMD_PX_SET;
         fhf_pkg::ST_PX_MUL:  cmd = fhf_pkg::CMD_PX_MUL;
         fhf_pkg::ST_PX_DIV:  cmd = fhf_pkg::CMD_PX_DIV;
         fhf_pkg::ST_PX_CMP:  cmd = fhf_pkg::CMD_PX_CMP;
         fhf_pkg::ST_FL_DEC:  cmd = fhf_pkg::CMD_FL_DEC;
         fhf_pkg::ST_MV_RD:   cmd = fhf_pkg::CMD_MV_RD;
         fhf_pkg::ST_MV_WR:   cmd = fhf_pkg::CMD_MV_WR;
         fhf_pkg::ST_MV_END:  cmd = fhf_pkg::CMD_MV_END;
         fhf_pkg::ST_DONE:    rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fhf_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/fire_heat_field_engine.sv
// channel   ports                                   handshake
// request   req_func, req_pixel_column, req_pixel_row,
//           req_heat_value, req_chance_roll,
//           req_flare_x, req_flare_y                 start && !busy
// response  rsp_heat_out, rsp_flare_count            rsp_valid, one cycle
// config    csr_index, csr_wdata                     csr_we
//
// One item at a time; busy stays high until the response strobe.
// Read and reheat use a RAM read state, then a capture or write state; shift reads then writes
// each entry it moves (one heat RAM port). Flare step: per flare about z*10/decay divide steps,
// then per glow-window pixel an iterative square root and multiply, divide and compare states,
// plus a read and a write per entry moved when a flare is dropped. After reset a clearing pass
// writes all ROWS*COLS heat RAM entries, one entry a cycle. The response cannot be stalled.
`default_nettype none
module fire_heat_field_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [fhf_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [fhf_pkg::POS_W-1:0]     req_pixel_column,
   input  wire logic [fhf_pkg::POS_W-1:0]     req_pixel_row,
   input  wire logic [fhf_pkg::HW-1:0]        req_heat_value,
   input  wire logic [fhf_pkg::ROLL_W-1:0]    req_chance_roll,
   input  wire logic [fhf_pkg::POS_W-1:0]     req_flare_x,
   input  wire logic [fhf_pkg::POS_W-1:0]     req_flare_y,
   output logic                               rsp_valid,
   output logic      [fhf_pkg::HW-1:0]        rsp_heat_out,
   output logic      [fhf_pkg::COUNT_W-1:0]   rsp_flare_count,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [fhf_pkg::CSR_W-1:0]     csr_wdata
);

   fhf_pkg::cmd_type    cmd;
   fhf_pkg::status_type status;

   fhf_controller u_ctrl (
      .clock(clock), .reset(reset), .start(start), .func(req_func),
      .status(status), .cmd(cmd), .busy(busy), .rsp_valid(rsp_valid)
   );

   fhf_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_pixel_column(req_pixel_column), .req_pixel_row(req_pixel_row),
      .req_heat_value(req_heat_value), .req_chance_roll(req_chance_roll),
      .req_flare_x(req_flare_x), .req_flare_y(req_flare_y),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .heat_out(rsp_heat_out), .flare_count(rsp_flare_count)
   );

endmodule
`default_nettype wire

### hw/rtl/fhf_checker.sv
`default_nettype none
module fhf_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        rsp_valid,
   input wire logic [fhf_pkg::HW-1:0]      rsp_heat_out,
   input wire logic [fhf_pkg::COUNT_W-1:0] rsp_flare_count
);

   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item did not raise busy");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response while idle");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_flare_count) <= fhf_pkg::MAX_FLARES))
      else $error("flare count out of range");

   a_heat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_heat_out) <= fhf_pkg::HEAT_MAX))
      else $error("heat out of range");

endmodule

bind fire_heat_field_engine fhf_checker u_fhf_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_heat_out(rsp_heat_out), .rsp_flare_count(rsp_flare_count)
);
`default_nettype wire
